// ===== sv/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is high
`define CSRC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked assertion that also holds across reset
`define CSRC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== sv/csrc_pkg.sv =====
// types and constants of the capacity split route cost block
package csrc_pkg;

   localparam int NODE_W  = 8;
   localparam int VALUE_W = 16;
   localparam int SUM_W   = 25;
   localparam int FRAC_W  = 16;
   localparam int LOAD_W  = 17;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   localparam logic [1:0] MODE_DEMAND = 2'd0;
   localparam logic [1:0] MODE_DIST   = 2'd1;
   localparam logic [1:0] MODE_TOUR   = 2'd2;

   localparam logic CSR_IDX_CAPACITY = 1'b0;

   typedef struct packed {
      logic [1:0]         mode;
      logic [NODE_W-1:0]  node_from;
      logic [NODE_W-1:0]  node_to;
      logic [VALUE_W-1:0] write_value;
      logic               tour_last;
   } req_payload_type;

   typedef struct packed {
      logic [SUM_W-1:0]  total_distance;
      logic [SUM_W-1:0]  return_distance;
      logic [FRAC_W-1:0] return_fraction;
      logic              overload;
   } rsp_payload_type;

   typedef struct packed {
      logic dem_wr;
      logic dist_wr;
      logic tour_start;
      logic decide;
      logic leg;
      logic ret;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

// ===== sv/csrc_if.sv =====
// item channel interfaces for requests and results
interface csrc_req_if;
   logic                      valid;
   logic                      ready;
   csrc_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface csrc_rsp_if;
   logic                      valid;
   logic                      ready;
   csrc_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/csrc_div.sv =====
// bit-serial restoring divider for the return fraction
module csrc_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             step,
   input  logic [csrc_pkg::SUM_W-1:0]       numer,
   input  logic [csrc_pkg::SUM_W-1:0]       denom,
   output logic [csrc_pkg::FRAC_W-1:0]      quot,
   output logic                             last
);

   localparam int CNT_W = $clog2(csrc_pkg::FRAC_W);

   logic [csrc_pkg::SUM_W-1:0]  rem_ff, rem_in;
   logic [csrc_pkg::FRAC_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [csrc_pkg::SUM_W:0]    rem_shift;
   logic [csrc_pkg::SUM_W:0]    rem_diff;
   logic                        fits;

   always_comb begin
      rem_shift = {rem_ff, 1'b0};
      rem_diff  = rem_shift - {1'b0, denom};
      fits      = rem_shift >= {1'b0, denom};
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      cnt_in    = cnt_ff;
      if (start) begin
         rem_in  = numer;
         quot_in = '0;
         cnt_in  = '0;
      end else if (step) begin
         rem_in  = fits ? rem_diff[csrc_pkg::SUM_W-1:0] : rem_shift[csrc_pkg::SUM_W-1:0];
         quot_in = {quot_ff[csrc_pkg::FRAC_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign quot = quot_ff;
   assign last = (cnt_ff == CNT_W'(csrc_pkg::FRAC_W - 1));

endmodule

// ===== sv/csrc_ctrl.sv =====
// sequencer for table writes, tour steps, divide and result hand-off
module csrc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_mode,
   output logic                   req_ready,
   input  csrc_pkg::status_type   st,
   output csrc_pkg::cmd_type      cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECIDE = 6'b000010,
      ST_LEG    = 6'b000100,
      ST_RET    = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_mode)
                  csrc_pkg::MODE_DEMAND: cmd.dem_wr = 1'b1;
                  csrc_pkg::MODE_DIST:   cmd.dist_wr = 1'b1;
                  csrc_pkg::MODE_TOUR: begin
                     cmd.tour_start = 1'b1;
                     state_in       = ST_DECIDE;
                  end
                  default: ;
               endcase
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_LEG;
         end
         ST_LEG: begin
            cmd.leg  = 1'b1;
            state_in = st.last ? ST_RET : ST_IDLE;
         end
         ST_RET: begin
            cmd.ret  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/csrc_dp.sv =====
// tables, route state, leg sums, divider and result register
module csrc_dp #(
   parameter int MAX_NODES = 256,
   parameter int DIST_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  csrc_pkg::cmd_type                      cmd,
   output csrc_pkg::status_type                   st,
   input  csrc_pkg::req_payload_type              req_data,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output csrc_pkg::rsp_payload_type              rsp_data,
   input  logic                                   cfg_wr,
   input  logic [csrc_pkg::VALUE_W-1:0]           cfg_wdata,
   output logic [csrc_pkg::VALUE_W-1:0]           cap_value
);

   localparam int IDX_W    = (MAX_NODES >= 256) ? csrc_pkg::NODE_W : $clog2(MAX_NODES);
   localparam int DEM_DEP  = 1 << IDX_W;
   localparam int DIST_DEP = 1 << (2 * IDX_W);
   localparam int WIDE_W   = ((DIST_BITS > csrc_pkg::SUM_W) ? DIST_BITS : csrc_pkg::SUM_W) + 1;
   localparam int CMP_W    = csrc_pkg::LOAD_W + 1;

   typedef logic [csrc_pkg::NODE_W-1:0]  node_type;
   typedef logic [csrc_pkg::SUM_W-1:0]   sum_type;
   typedef logic [csrc_pkg::VALUE_W-1:0] value_type;

   function automatic logic in_range(input node_type n);
      in_range = (32'(n) < 32'(MAX_NODES));
   endfunction

   function automatic sum_type sat_add(input sum_type acc, input logic [DIST_BITS-1:0] leg);
      logic [WIDE_W-1:0] s;
      s = WIDE_W'(acc) + WIDE_W'(leg);
      sat_add = (s > WIDE_W'(csrc_pkg::SUM_MAX)) ? csrc_pkg::SUM_MAX : s[csrc_pkg::SUM_W-1:0];
   endfunction

   value_type                dem_mem [DEM_DEP];
   logic [DIST_BITS-1:0]     dist_mem [DIST_DEP];
   value_type                dem_q_ff;
   logic                     dem_ok_ff;
   logic [DIST_BITS-1:0]     dist_q_ff;
   logic                     dist_ok_ff;

   value_type                cap_ff;
   node_type                 node_ff;
   logic                     last_ff;
   logic [csrc_pkg::LOAD_W-1:0] load_ff, load_in;
   node_type                 prev_ff, prev_in;
   logic                     open_ff, open_in;
   sum_type                  dsum_ff, dsum_in;
   sum_type                  rsum_ff, rsum_in;
   logic                     over_ff, over_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   csrc_pkg::rsp_payload_type rsp_ff;

   node_type                 tour_node;
   value_type                demand;
   logic [DIST_BITS-1:0]     leg_val;
   logic                     close;
   logic                     open_eff;
   logic                     dist_re;
   node_type                 rd_from, rd_to;
   logic [csrc_pkg::FRAC_W-1:0] quot;
   logic [csrc_pkg::FRAC_W-1:0] frac;
   logic                     div_last;

   assign tour_node = req_data.node_from + 1'b1;
   assign demand    = dem_ok_ff ? dem_q_ff : '0;
   assign leg_val   = dist_ok_ff ? dist_q_ff : '0;
   assign close     = open_ff &&
                      ((CMP_W'(load_ff) + CMP_W'(demand)) >= CMP_W'(cap_ff));
   assign open_eff  = open_ff && !close;

   // distance read address follows the tour step being issued
   always_comb begin
      rd_from = '0;
      rd_to   = '0;
      dist_re = 1'b0;
      if (cmd.tour_start) begin
         rd_from = prev_ff;
         dist_re = 1'b1;
      end else if (cmd.decide) begin
         rd_from = open_eff ? prev_ff : '0;
         rd_to   = node_ff;
         dist_re = 1'b1;
      end else if (cmd.leg) begin
         rd_from = node_ff;
         dist_re = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.dem_wr && in_range(req_data.node_from)) begin
         dem_mem[req_data.node_from[IDX_W-1:0]] <= req_data.write_value;
      end
      if (cmd.tour_start) begin
         dem_q_ff  <= dem_mem[tour_node[IDX_W-1:0]];
         dem_ok_ff <= in_range(tour_node);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.dist_wr && in_range(req_data.node_from) && in_range(req_data.node_to)) begin
         dist_mem[{req_data.node_from[IDX_W-1:0], req_data.node_to[IDX_W-1:0]}] <=
            DIST_BITS'(req_data.write_value);
      end
      if (dist_re) begin
         dist_q_ff  <= dist_mem[{rd_from[IDX_W-1:0], rd_to[IDX_W-1:0]}];
         dist_ok_ff <= in_range(rd_from) && in_range(rd_to);
      end
   end

   always_comb begin
      load_in      = load_ff;
      prev_in      = prev_ff;
      open_in      = open_ff;
      dsum_in      = dsum_ff;
      rsum_in      = rsum_ff;
      over_in      = over_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.decide) begin
         // close the open route when load plus this customer's demand reaches the capacity
         if (close) begin
            dsum_in = sat_add(dsum_ff, leg_val);
            rsum_in = sat_add(rsum_ff, leg_val);
            load_in = '0;
         end
         open_in = open_eff;
         if (!open_eff && (demand >= cap_ff)) begin
            over_in = 1'b1;
         end
      end
      if (cmd.leg) begin
         dsum_in = sat_add(dsum_ff, leg_val);
         load_in = load_ff + csrc_pkg::LOAD_W'(demand);
         prev_in = node_ff;
         open_in = 1'b1;
      end
      if (cmd.ret) begin
         dsum_in = sat_add(dsum_ff, leg_val);
         rsum_in = sat_add(rsum_ff, leg_val);
      end
      if (cmd.out_load) begin
         load_in      = '0;
         prev_in      = '0;
         open_in      = 1'b0;
         dsum_in      = '0;
         rsum_in      = '0;
         over_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff      <= '0;
         prev_ff      <= '0;
         open_ff      <= 1'b0;
         dsum_ff      <= '0;
         rsum_ff      <= '0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= '1;
      end else begin
         load_ff      <= load_in;
         prev_ff      <= prev_in;
         open_ff      <= open_in;
         dsum_ff      <= dsum_in;
         rsum_ff      <= rsum_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_wr) begin
            cap_ff <= cfg_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tour_start) begin
         node_ff <= tour_node;
         last_ff <= req_data.tour_last;
      end
      if (cmd.out_load) begin
         rsp_ff.total_distance  <= dsum_ff;
         rsp_ff.return_distance <= rsum_ff;
         rsp_ff.return_fraction <= frac;
         rsp_ff.overload        <= over_ff;
      end
   end

   // a zero total gives a zero fraction; returns never exceed the total, so equal sums saturate it
   always_comb begin
      if (dsum_ff == '0) begin
         frac = '0;
      end else if (rsum_ff == dsum_ff) begin
         frac = '1;
      end else begin
         frac = quot;
      end
   end

   csrc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.ret),
      .step  (cmd.div_step),
      .numer (rsum_in),
      .denom (dsum_ff),
      .quot  (quot),
      .last  (div_last)
   );

   assign st.last     = last_ff;
   assign st.div_last = div_last;
   assign st.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;
   assign cap_value   = cap_ff;

endmodule

// ===== sv/capacity_split_route_cost.sv =====
// top level: item channels, register port, controller and datapath
//
//  channel   direction  handshake            payload
//  req_port  in         valid/ready          mode, node_from, node_to, write_value, tour_last
//  rsp_port  out        valid/ready          total_distance, return_distance,
//                                            return_fraction, overload
//  apb       in         psel/penable/pready  vehicle_capacity at byte address 0
//
// a demand or distance write is done in the idle state; a customer steps through a demand read,
// one distance read per leg on the single distance memory port, and a leg add
// the last customer adds a return leg and a 16-bit bit-serial divide before the result
// reset is synchronous, clears tour state and sets the capacity to its maximum;
// the tables are never cleared
// input is taken only between items; a stalled result holds only the next tour's end
module capacity_split_route_cost #(
   parameter int MAX_NODES = 256,
   parameter int DIST_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   csrc_req_if.sink                             req_port,
   csrc_rsp_if.source                           rsp_port,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [csrc_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [csrc_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [csrc_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   csrc_pkg::cmd_type    cmd;
   csrc_pkg::status_type st;
   logic                 cfg_wr;
   logic [csrc_pkg::VALUE_W-1:0] cap_value;

   always_comb begin
      cfg_wr = 1'b0;
      prdata = '0;
      unique case (paddr[2])
         csrc_pkg::CSR_IDX_CAPACITY: begin
            cfg_wr = psel && penable && pwrite;
            prdata = csrc_pkg::CSR_DATA_W'(cap_value);
         end
         default: ;
      endcase
   end

   assign pready = 1'b1;

   csrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_mode  (req_port.data.mode),
      .req_ready (req_port.ready),
      .st        (st),
      .cmd       (cmd)
   );

   csrc_dp #(
      .MAX_NODES (MAX_NODES),
      .DIST_BITS (DIST_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .st        (st),
      .req_data  (req_port.data),
      .rsp_ready (rsp_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_data  (rsp_port.data),
      .cfg_wr    (cfg_wr),
      .cfg_wdata (pwdata[csrc_pkg::VALUE_W-1:0]),
      .cap_value (cap_value)
   );

endmodule

// ===== sv/csrc_checker.sv =====
// port-level checks of the route cost block, bound to the top level
`include "assert_macros.svh"

module csrc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [1:0]                        req_mode,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [csrc_pkg::SUM_W-1:0]        total_distance,
   input logic [csrc_pkg::SUM_W-1:0]        return_distance,
   input logic [csrc_pkg::FRAC_W-1:0]       return_fraction,
   input logic                              overload
);

   logic                                        tour_taken;
   logic                                        zero_total;
   logic                                        zero_frac;
   logic [2*csrc_pkg::SUM_W+csrc_pkg::FRAC_W:0] rsp_fields;

   assign tour_taken = req_valid && req_ready && (req_mode == csrc_pkg::MODE_TOUR);
   assign zero_total = (total_distance == '0);
   assign zero_frac  = (return_fraction == '0);
   assign rsp_fields = {total_distance, return_distance, return_fraction, overload};

   // the block is ready for an item right after reset
   `CSRC_ASSERT_ALWAYS(a_ready_after_reset, clock, reset |=> req_ready)

   // taking a tour item leaves the block busy, so it drops ready
   `CSRC_ASSERT(a_tour_busy, clock, reset, tour_taken |=> !req_ready)

   // return legs are a part of the total
   `CSRC_ASSERT(a_return_le_total, clock, reset, rsp_valid |-> (return_distance <= total_distance))

   // a zero total distance gives a zero fraction
   `CSRC_ASSERT(a_zero_total_frac, clock, reset, (rsp_valid && zero_total) |-> zero_frac)

   // a stalled result holds its fields
   `CSRC_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> $stable(rsp_fields))

endmodule

bind capacity_split_route_cost csrc_checker u_csrc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_port.valid),
   .req_ready       (req_port.ready),
   .req_mode        (req_port.data.mode),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .total_distance  (rsp_port.data.total_distance),
   .return_distance (rsp_port.data.return_distance),
   .return_fraction (rsp_port.data.return_fraction),
   .overload        (rsp_port.data.overload)
);
